>>> src/hsse_pkg.sv
// Shared types and constants of the half-symbol SNR estimator.
package hsse_pkg;

    localparam int MAX_HALF_LEN = 512;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LEN_WIDTH = 10;
    localparam int POS_WIDTH = $clog2(2 * MAX_HALF_LEN);
    localparam int ADDR_WIDTH = $clog2(MAX_HALF_LEN);
    localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH;
    localparam int ACC_WIDTH = 48;
    localparam int OUT_WIDTH = 32;
    localparam int FRAC_BITS = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_WIDTH-1:0] HALF_LENGTH_RESET = LEN_WIDTH'(32);
    localparam logic [OUT_WIDTH-1:0] OUT_MIN = OUT_WIDTH'(410);
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = OUT_WIDTH'(32'd4096000000);
    localparam logic [OUT_WIDTH-1:0] OUT_LIMITED = OUT_WIDTH'(204795904);
    localparam logic [15:0] LIM_NUM = 16'd50000;
    localparam logic [15:0] LIM_DEN = 16'd49999;

    typedef struct packed {
        logic [ACC_WIDTH-1:0] corr_re;
        logic [ACC_WIDTH-1:0] corr_im;
        logic [ACC_WIDTH-1:0] power;
    } acc_t;

endpackage

>>> src/hsse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hsse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/hsse_front.sv
// Front part: sample intake, first-half store and correlation and power accumulation.
module hsse_front import hsse_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [LEN_WIDTH-1:0]         cfg_wdata,
    input  logic                         in_fire,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
    output logic                         push,
    output acc_t                         push_data,
    output logic [QCNT_WIDTH-1:0]        pend_count
);

    logic [LEN_WIDTH-1:0] half_length_reg;
    logic [LEN_WIDTH-1:0] len_eff;
    logic [POS_WIDTH-1:0] pos_reg;
    logic [POS_WIDTH-1:0] last_pos;
    logic                 is_first;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_WIDTH-1:0] ram_waddr;
    logic [ADDR_WIDTH-1:0] ram_raddr;
    logic [PROD_WIDTH-1:0] ram_rdata;

    logic s1_valid_reg;
    logic s1_second_reg;
    logic s1_last_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_im_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_re;
    logic signed [SAMPLE_WIDTH-1:0] a_im;

    logic s2_valid_reg;
    logic s2_second_reg;
    logic s2_last_reg;
    logic signed [PROD_WIDTH-1:0] p_rr_reg;
    logic signed [PROD_WIDTH-1:0] p_ii_reg;
    logic signed [PROD_WIDTH-1:0] p_ri_reg;
    logic signed [PROD_WIDTH-1:0] p_ir_reg;
    logic signed [PROD_WIDTH-1:0] sq_r_reg;
    logic signed [PROD_WIDTH-1:0] sq_i_reg;

    logic [ACC_WIDTH-1:0] corr_re_reg;
    logic [ACC_WIDTH-1:0] corr_im_reg;
    logic [ACC_WIDTH-1:0] power_reg;
    logic [ACC_WIDTH-1:0] corr_re_sum;
    logic [ACC_WIDTH-1:0] corr_im_sum;
    logic [ACC_WIDTH-1:0] power_sum;

    always_comb
    begin
        if (half_length_reg == '0)
        begin
            len_eff = LEN_WIDTH'(1);
        end
        else if (32'(half_length_reg) > MAX_HALF_LEN)
        begin
            len_eff = LEN_WIDTH'(MAX_HALF_LEN);
        end
        else
        begin
            len_eff = half_length_reg;
        end
    end

    assign last_pos  = POS_WIDTH'((32'(len_eff) << 1) - 32'd1);
    assign is_first  = 32'(pos_reg) < 32'(len_eff);
    assign ram_we    = in_fire && is_first;
    assign ram_re    = in_fire && !is_first;
    assign ram_waddr = pos_reg[ADDR_WIDTH-1:0];
    assign ram_raddr = ADDR_WIDTH'(32'(pos_reg) - 32'(len_eff));

    hsse_ram #(
        .WIDTH(PROD_WIDTH),
        .DEPTH(MAX_HALF_LEN)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({sample_re, sample_im}),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign a_re = ram_rdata[PROD_WIDTH-1:SAMPLE_WIDTH];
    assign a_im = ram_rdata[SAMPLE_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= HALF_LENGTH_RESET;
            pos_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_length_reg <= cfg_wdata;
                pos_reg         <= '0;
            end
            else if (in_fire)
            begin
                if (pos_reg >= last_pos)
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_WIDTH'(1);
                end
            end
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_second_reg <= !is_first;
        s1_last_reg   <= pos_reg == last_pos;
        s1_re_reg     <= sample_re;
        s1_im_reg     <= sample_im;
        s2_second_reg <= s1_second_reg;
        s2_last_reg   <= s1_last_reg;
        p_rr_reg      <= a_re * s1_re_reg;
        p_ii_reg      <= a_im * s1_im_reg;
        p_ri_reg      <= a_re * s1_im_reg;
        p_ir_reg      <= a_im * s1_re_reg;
        sq_r_reg      <= s1_re_reg * s1_re_reg;
        sq_i_reg      <= s1_im_reg * s1_im_reg;
    end

    always_comb
    begin
        power_sum = power_reg + ACC_WIDTH'(sq_r_reg) + ACC_WIDTH'(sq_i_reg);
        if (s2_second_reg)
        begin
            corr_re_sum = corr_re_reg + ACC_WIDTH'(p_rr_reg) + ACC_WIDTH'(p_ii_reg);
            corr_im_sum = corr_im_reg + ACC_WIDTH'(p_ri_reg) - ACC_WIDTH'(p_ir_reg);
        end
        else
        begin
            corr_re_sum = corr_re_reg;
            corr_im_sum = corr_im_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_re_reg <= '0;
            corr_im_reg <= '0;
            power_reg   <= '0;
        end
        else if (cfg_we || (s2_valid_reg && s2_last_reg))
        begin
            corr_re_reg <= '0;
            corr_im_reg <= '0;
            power_reg   <= '0;
        end
        else if (s2_valid_reg)
        begin
            corr_re_reg <= corr_re_sum;
            corr_im_reg <= corr_im_sum;
            power_reg   <= power_sum;
        end
    end

    assign push              = s2_valid_reg && s2_last_reg;
    assign push_data.corr_re = corr_re_sum;
    assign push_data.corr_im = corr_im_sum;
    assign push_data.power   = power_sum;
    assign pend_count = QCNT_WIDTH'(s1_valid_reg && s1_last_reg)
                      + QCNT_WIDTH'(s2_valid_reg && s2_last_reg);

`ifndef SYNTH
    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("Store written and read in the same cycle.");
`endif

endmodule

>>> src/hsse_queue.sv
// Short queue of per-symbol accumulator sets between the front and back parts.
module hsse_queue import hsse_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  acc_t                  push_data,
    input  logic                  pop,
    output logic                  pop_valid,
    output acc_t                  pop_data,
    output logic [QCNT_WIDTH-1:0] count
);

    localparam int QADDR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    acc_t                   entry_reg [QUEUE_DEPTH];
    logic [QADDR_WIDTH-1:0] wr_ptr_reg;
    logic [QADDR_WIDTH-1:0] rd_ptr_reg;
    logic [QCNT_WIDTH-1:0]  count_reg;

    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                if (32'(wr_ptr_reg) == QUEUE_DEPTH - 1)
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + QADDR_WIDTH'(1);
                end
            end
            if (pop)
            begin
                if (32'(rd_ptr_reg) == QUEUE_DEPTH - 1)
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + QADDR_WIDTH'(1);
                end
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_WIDTH'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_WIDTH'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && 32'(count_reg) == QUEUE_DEPTH))
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0))
        else $error("Queue read while empty.");
`endif

endmodule

>>> src/hsse_back.sv
// Back part: magnitude, limit test, ratio division and the output register.
module hsse_back import hsse_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  acc_t                 pop_data,
    output logic                 pop,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [OUT_WIDTH-1:0] snr_estimate
);

    localparam int HALF = ACC_WIDTH / 2;
    localparam int SQ_WIDTH = 2 * ACC_WIDTH;
    localparam int ROOT_WIDTH = ACC_WIDTH;
    localparam int REM_WIDTH = ROOT_WIDTH + 2;
    localparam int T_WIDTH = ROOT_WIDTH + 1;
    localparam int LIM_WIDTH = T_WIDTH + 16;
    localparam int DVD_WIDTH = T_WIDTH + FRAC_BITS;
    localparam int STEP_WIDTH = $clog2(DVD_WIDTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQUARE = 8'b0000_0010,
        ST_ROOT   = 8'b0000_0100,
        ST_SCALE  = 8'b0000_1000,
        ST_DECIDE = 8'b0001_0000,
        ST_DIVIDE = 8'b0010_0000,
        ST_CLAMP  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [ACC_WIDTH-1:0]  ar_reg;
    logic [ACC_WIDTH-1:0]  ai_reg;
    logic [ACC_WIDTH-1:0]  r_reg;
    logic [SQ_WIDTH-1:0]   sq_reg;
    logic [REM_WIDTH-1:0]  rem_reg;
    logic [ROOT_WIDTH-1:0] root_reg;
    logic [LIM_WIDTH-1:0]  prod_t_reg;
    logic [LIM_WIDTH-1:0]  prod_r_reg;
    logic [DVD_WIDTH-1:0]  quo_reg;
    logic [ACC_WIDTH-1:0]  drem_reg;
    logic [ACC_WIDTH-1:0]  div_reg;
    logic [OUT_WIDTH-1:0]  res_reg;
    logic                  out_valid_reg;
    logic [OUT_WIDTH-1:0]  snr_reg;

    logic [ACC_WIDTH-1:0]  sq_op;
    logic [HALF-1:0]       sq_x;
    logic [HALF-1:0]       sq_y;
    logic [ACC_WIDTH-1:0]  sq_prod;
    logic [SQ_WIDTH-1:0]   sq_term;
    logic [REM_WIDTH+1:0]  rem_sh;
    logic [REM_WIDTH+1:0]  trial;
    logic [T_WIDTH-1:0]    t_val;
    logic [ACC_WIDTH:0]    dr_sh;
    logic                  dr_ge;
    logic                  load_out;

    function automatic logic [ACC_WIDTH-1:0] abs_acc(input logic [ACC_WIDTH-1:0] v);
        if (v[ACC_WIDTH-1])
        begin
            return (~v) + ACC_WIDTH'(1);
        end
        return v;
    endfunction

    assign sq_op   = step_reg[2] ? ai_reg : ar_reg;
    assign sq_x    = step_reg[1] ? sq_op[ACC_WIDTH-1:HALF] : sq_op[HALF-1:0];
    assign sq_y    = step_reg[0] ? sq_op[ACC_WIDTH-1:HALF] : sq_op[HALF-1:0];
    assign sq_prod = sq_x * sq_y;

    always_comb
    begin
        case (step_reg[1:0])
            2'b00:   sq_term = SQ_WIDTH'(sq_prod);
            2'b11:   sq_term = SQ_WIDTH'(sq_prod) << (2 * HALF);
            default: sq_term = SQ_WIDTH'(sq_prod) << HALF;
        endcase
    end

    assign rem_sh = {rem_reg, sq_reg[SQ_WIDTH-1:SQ_WIDTH-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign t_val  = {root_reg, 1'b0};
    assign dr_sh  = {drem_reg, quo_reg[DVD_WIDTH-1]};
    assign dr_ge  = dr_sh >= {1'b0, div_reg};

    assign pop      = (state_reg == ST_IDLE) && pop_valid;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    if (step_reg == STEP_WIDTH'(7))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_WIDTH'(1);
                    end
                end
                ST_ROOT:
                begin
                    if (step_reg == STEP_WIDTH'(ROOT_WIDTH - 1))
                    begin
                        state_reg <= ST_SCALE;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_WIDTH'(1);
                    end
                end
                ST_SCALE:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    step_reg <= '0;
                    if (r_reg == '0 || T_WIDTH'(r_reg) <= t_val || prod_t_reg > prod_r_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (step_reg == STEP_WIDTH'(DVD_WIDTH - 1))
                    begin
                        state_reg <= ST_CLAMP;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_WIDTH'(1);
                    end
                end
                ST_CLAMP:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ar_reg <= abs_acc(pop_data.corr_re);
                ai_reg <= abs_acc(pop_data.corr_im);
                r_reg  <= pop_data.power;
                sq_reg <= '0;
            end
            ST_SQUARE:
            begin
                sq_reg   <= sq_reg + sq_term;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_ROOT:
            begin
                sq_reg <= sq_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= REM_WIDTH'(rem_sh - trial);
                    root_reg <= {root_reg[ROOT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= REM_WIDTH'(rem_sh);
                    root_reg <= {root_reg[ROOT_WIDTH-2:0], 1'b0};
                end
            end
            ST_SCALE:
            begin
                prod_t_reg <= LIM_WIDTH'(t_val) * LIM_WIDTH'(LIM_NUM);
                prod_r_reg <= LIM_WIDTH'(r_reg) * LIM_WIDTH'(LIM_DEN);
            end
            ST_DECIDE:
            begin
                quo_reg  <= DVD_WIDTH'(t_val) << FRAC_BITS;
                drem_reg <= '0;
                div_reg  <= ACC_WIDTH'(T_WIDTH'(r_reg) - t_val);
                if (r_reg == '0)
                begin
                    res_reg <= OUT_MIN;
                end
                else
                begin
                    res_reg <= OUT_LIMITED;
                end
            end
            ST_DIVIDE:
            begin
                if (dr_ge)
                begin
                    drem_reg <= ACC_WIDTH'(dr_sh - {1'b0, div_reg});
                end
                else
                begin
                    drem_reg <= ACC_WIDTH'(dr_sh);
                end
                quo_reg <= {quo_reg[DVD_WIDTH-2:0], dr_ge};
            end
            ST_CLAMP:
            begin
                if (quo_reg > DVD_WIDTH'(OUT_MAX))
                begin
                    res_reg <= OUT_MAX;
                end
                else if (quo_reg < DVD_WIDTH'(OUT_MIN))
                begin
                    res_reg <= OUT_MIN;
                end
                else
                begin
                    res_reg <= quo_reg[OUT_WIDTH-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            snr_reg <= res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign snr_estimate = snr_reg;

endmodule

>>> src/half_symbol_snr_estimator.sv
// Top level of the half-symbol SNR estimator.
// The block takes one complex sample per cycle while in_stall is low and gives one SNR
// estimate per symbol of twice half_length samples, once the back part has worked
// through the symbol: squaring on one 24 by 24 bit multiplier, bit-serial square root,
// the limit test and, unless the limit test settles the result, bit-serial division.
// A queue of two symbols lets the back part run while the next symbols arrive, so
// symbols of 122 samples or more stream without stalls; shorter symbols see in_stall
// raised while the queue is full. Writing half_length restarts the current symbol; the
// user must write it only while the block is idle, and the block does not enforce this.
module half_symbol_snr_estimator import hsse_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [LEN_WIDTH-1:0]           cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [OUT_WIDTH-1:0]           snr_estimate
);

    logic                  in_fire;
    logic                  push;
    acc_t                  push_data;
    logic [QCNT_WIDTH-1:0] pend_count;
    logic                  pop;
    logic                  pop_valid;
    acc_t                  pop_data;
    logic [QCNT_WIDTH-1:0] q_count;

    assign in_stall = ({1'b0, q_count} + {1'b0, pend_count}) >= (QCNT_WIDTH + 1)'(QUEUE_DEPTH);
    assign in_fire  = in_valid && !in_stall;

    hsse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .push      (push),
        .push_data (push_data),
        .pend_count(pend_count)
    );

    hsse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_valid(pop_valid),
        .pop_data (pop_data),
        .count    (q_count)
    );

    hsse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .snr_estimate(snr_estimate)
    );

`ifndef SYNTH
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (snr_estimate >= OUT_MIN && snr_estimate <= OUT_MAX))
        else $error("Estimate outside its saturation range.");
`endif

endmodule
